>>> sv/hvt_pkg.sv
// Shared types and constants for the hex text value tokenizer.
package hvt_pkg;

   localparam int unsigned TEXT_W      = 8;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned RSP_TDATA_W = 40;

   localparam logic [TEXT_W-1:0] CHR_TAB   = 8'h09;
   localparam logic [TEXT_W-1:0] CHR_LF    = 8'h0A;
   localparam logic [TEXT_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [TEXT_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [TEXT_W-1:0] CHR_HASH  = 8'h23;
   localparam logic [TEXT_W-1:0] CHR_LO_X  = 8'h78;
   localparam logic [TEXT_W-1:0] CHR_UP_X  = 8'h58;

   localparam logic [VALUE_W-1:0] VALUE_SAT = '1;

   // digit machine of one token
   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_ZERO    = 3'd1,
      PH_DIGITS  = 3'd2,
      PH_AFTER_X = 3'd3,
      PH_DONE    = 3'd4,
      PH_DEAD    = 3'd5
   } hvt_phase_type;

   typedef struct packed {
      logic               is_digit;
      logic [DIGIT_W-1:0] digit;
      logic               is_x;
      logic               is_sep;
      logic               is_hash;
      logic               is_eol;
   } hvt_class_type;

   typedef struct packed {
      logic               fire;
      logic [VALUE_W-1:0] value;
      logic               sat;
      logic               no_digits;
      logic               err;
   } hvt_result_type;

endpackage

>>> sv/hvt_char_class.sv
// Byte classifier: hex digit value, prefix letter, separators, line ends.
module hvt_char_class (
   input  logic [hvt_pkg::TEXT_W-1:0] text_byte,
   output hvt_pkg::hvt_class_type     cls
);
   import hvt_pkg::*;

   always_comb begin
      cls          = '0;
      cls.is_x     = (text_byte == CHR_LO_X) || (text_byte == CHR_UP_X);
      cls.is_hash  = (text_byte == CHR_HASH);
      cls.is_eol   = (text_byte == CHR_LF) || (text_byte == CHR_CR);
      cls.is_sep   = text_byte inside {CHR_TAB, CHR_LF, CHR_CR, CHR_SPACE, CHR_HASH};
      if (text_byte inside {[8'h30:8'h39]}) begin
         cls.is_digit = 1'b1;
         cls.digit    = text_byte[DIGIT_W-1:0];
      end else if (text_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         cls.is_digit = 1'b1;
         cls.digit    = text_byte[DIGIT_W-1:0] + 4'd9;
      end
   end

endmodule

>>> sv/hvt_token_core.sv
// Token state: comment flag, digit machine, accumulator, sticky error, result.
module hvt_token_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  hvt_pkg::hvt_class_type cls,
   output hvt_pkg::hvt_result_type res
);
   import hvt_pkg::*;

   hvt_phase_type      phase_ff, phase_in;
   logic               in_comment_ff, in_comment_in;
   logic               token_open_ff, token_open_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic               err_ff, err_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;

   logic hexish, tok_step, close_tok, take_digit, empty_tok;

   assign hexish    = cls.is_digit || cls.is_x;
   assign close_tok = !in_comment_ff && cls.is_sep && token_open_ff;
   // byte that drives the digit machine (closed token is always fresh)
   assign tok_step  = !in_comment_ff && !cls.is_sep && (hexish || token_open_ff);
   assign empty_tok = (phase_ff == PH_START) || (phase_ff == PH_DEAD);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (close_tok) begin
         phase_in = PH_START;
      end else if (tok_step) begin
         case (phase_ff)
            PH_START: begin
               if (!cls.is_digit)          phase_in = PH_DEAD;
               else if (cls.digit == '0)   phase_in = PH_ZERO;
               else                        phase_in = PH_DIGITS;
            end
            PH_ZERO: begin
               if (cls.is_digit)           phase_in = PH_DIGITS;
               else if (cls.is_x)          phase_in = PH_AFTER_X;
               else                        phase_in = PH_DONE;
            end
            PH_DIGITS, PH_AFTER_X: begin
               phase_in = cls.is_digit ? PH_DIGITS : PH_DONE;
            end
            PH_DONE: phase_in = PH_DONE;
            default: phase_in = PH_DEAD;
         endcase
      end
   end

   assign take_digit = tok_step && cls.is_digit &&
                       ((phase_ff == PH_START && cls.digit != '0) ||
                        phase_ff == PH_ZERO || phase_ff == PH_DIGITS ||
                        phase_ff == PH_AFTER_X);

   // datapath and outputs
   always_comb begin
      in_comment_in = in_comment_ff;
      token_open_in = token_open_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      err_in        = err_ff;
      prev_in       = prev_ff;
      res           = '0;
      res.err       = err_ff;

      if (in_comment_ff) begin
         if (cls.is_eol) in_comment_in = 1'b0;
      end else if (cls.is_sep) begin
         if (cls.is_hash) in_comment_in = 1'b1;
         if (token_open_ff) begin
            token_open_in = 1'b0;
            acc_in        = '0;
            ovf_in        = 1'b0;
            res.fire      = 1'b1;
            if (empty_tok) begin
               res.value     = prev_ff;
               res.no_digits = 1'b1;
            end else begin
               res.value = ovf_ff ? VALUE_SAT : acc_ff;
               res.sat   = ovf_ff;
               prev_in   = res.value;
            end
         end
      end else begin
         if (hexish) token_open_in = 1'b1;
         else        err_in        = 1'b1;
      end

      if (take_digit && !ovf_ff) begin
         if (acc_ff[VALUE_W-1 -: DIGIT_W] != '0) begin
            ovf_in = 1'b1;
            acc_in = VALUE_SAT;
         end else begin
            acc_in = {acc_ff[VALUE_W-DIGIT_W-1:0], cls.digit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         in_comment_ff <= 1'b0;
         token_open_ff <= 1'b0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         err_ff        <= 1'b0;
         prev_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         in_comment_ff <= in_comment_in;
         token_open_ff <= token_open_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         err_ff        <= err_in;
         prev_ff       <= prev_in;
      end
   end

`ifndef SYNTHESIS
   a_closed_fresh: assert property (@(posedge clock) disable iff (reset)
      !token_open_ff |-> (phase_ff == PH_START && acc_ff == '0 && !ovf_ff))
      else $error("closed token holds stale digit state");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (acc_ff == VALUE_SAT))
      else $error("overflow without saturated accumulator");
   a_comment_closed: assert property (@(posedge clock) disable iff (reset)
      in_comment_ff |-> !token_open_ff)
      else $error("token open inside comment");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("syntax error flag cleared");
`endif

endmodule

>>> sv/hex_text_value_tokenizer.sv
// Path: an accepted byte lands in the input register; classify + token logic
//   then run on it and load the result register, from which a separator's
//   token value is offered on rsp_. Throughput: one byte per cycle, unless a
//   byte that makes a result meets a full result register not taken on rsp_;
//   the single token state update sets that pace.
//   The result register lets a new byte enter while a value waits on rsp_.
// Reset (synchronous, active high) empties both registers, closes any token
//   or comment, clears the error flag and sets the repeated value to zero.
module hex_text_value_tokenizer (
   input  logic                               clock,
   input  logic                               reset,
   // input byte stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hvt_pkg::TEXT_W-1:0]         req_tdata,  // [7:0] text_byte
   // token results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] number_value, [32] value_saturated, [33] no_digits,
   // [34] syntax_error_seen, [39:35] zero
   output logic [hvt_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import hvt_pkg::*;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [TEXT_W-1:0] s1_byte_ff, s1_byte_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   hvt_class_type  cls;
   hvt_result_type res;
   logic           s1_go, step;

   hvt_char_class u_class (
      .text_byte (s1_byte_ff),
      .cls       (cls)
   );

   hvt_token_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cls   (cls),
      .res   (res)
   );

   // the byte in s1 retires unless it makes a result and the result slot
   // stays occupied this cycle
   assign s1_go      = !res.fire || !out_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && s1_go;
   assign req_tready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_byte_in  = req_tdata;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step && res.fire) begin
         out_valid_in = 1'b1;
         out_data_in  = {{(RSP_TDATA_W-VALUE_W-3){1'b0}},
                         res.err, res.no_digits, res.sat, res.value};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[VALUE_W]) |-> (rsp_tdata[VALUE_W-1:0] == VALUE_SAT))
      else $error("saturated result without all-ones value");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[VALUE_W] && rsp_tdata[VALUE_W+1]))
      else $error("saturated and no-digit both set");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(step && res.fire))
      else $error("pending result overwritten");
`endif

endmodule
